FILE: rtl/stbb_pkg.sv
// Shared types, codes and hash constants of the sorted table builder.
`timescale 1ns / 1ps
`default_nettype none
package stbb_pkg;

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // MurmurHash3 x64 128 constants
  localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_F1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MM_SEED_LEN = 64'd9;  // seed 1 xor length 8

  // Hash program opcodes
  typedef logic [2:0] hop_t;
  localparam hop_t OP_MUL  = 3'd0;
  localparam hop_t OP_ROT  = 3'd1;
  localparam hop_t OP_MIX  = 3'd2;
  localparam hop_t OP_XS   = 3'd3;
  localparam hop_t OP_SWAP = 3'd4;
  localparam hop_t OP_FIN  = 3'd5;
  localparam hop_t OP_DIV  = 3'd6;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  // Hash program: one opcode per step
  function automatic hop_t prog_op(input pc_t pc);
    hop_t op;
    unique case (pc)
      5'd0, 5'd2, 5'd5, 5'd7, 5'd11, 5'd13: op = OP_MUL;
      5'd1:                                 op = OP_ROT;
      5'd3:                                 op = OP_MIX;
      5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14: op = OP_XS;
      5'd9:                                 op = OP_SWAP;
      5'd15:                                op = OP_FIN;
      default:                              op = OP_DIV;
    endcase
    return op;
  endfunction

  // Multiplier constant of each multiply step
  function automatic logic [63:0] prog_const(input pc_t pc);
    logic [63:0] c;
    unique case (pc)
      5'd0:         c = MM_C1;
      5'd2:         c = MM_C2;
      5'd5, 5'd11:  c = MM_F1;
      default:      c = MM_F2;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/stbb_hash.sv
// Sequential MurmurHash3 of one 64-bit key and reduction of its four words to filter indexes.
`timescale 1ns / 1ps
`default_nettype none
module stbb_hash #(
  parameter int FILTER_BITS = 10240,
  parameter int RW = $clog2(FILTER_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          key,
  output logic                 done,
  output logic [3:0][RW-1:0]   idx
);

  localparam logic [RW:0] DIVISOR = (RW+1)'(FILTER_BITS);
  localparam logic [31:0] DIV_W   = 32'(FILTER_BITS);
  // floor(2^(32+RW) / FILTER_BITS): the quotient estimate is at most one low
  localparam logic [32:0] RECIP   = 33'((64'd1 << (32 + RW)) / 64'(FILTER_BITS));
  localparam int          QW      = 33 - RW;

  logic                busy;
  stbb_pkg::pc_t       pc;
  logic [1:0]          ph;
  logic [63:0]         x;
  logic [63:0]         ha;
  logic [63:0]         hb;
  logic [63:0]         acc;
  logic [63:0]         prod;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         cst;
  stbb_pkg::hop_t      op;
  logic [64:0]         qprod;
  logic [QW-1:0]       q_est;
  logic [31:0]         qd;
  logic [31:0]         diff;
  logic [RW:0]         r0;
  logic [RW-1:0]       rem_fix;
  logic [1:0]          dcnt;
  logic [1:0]          wsel;
  logic [31:0]         word_sel;
  logic [63:0]         mixed;
  logic                red_last;

  assign op  = stbb_pkg::prog_op(pc);
  assign cst = stbb_pkg::prog_const(pc);

  // Pick multiplier operands for each partial product
  always_comb begin
    case (ph)
      2'd0:    begin mul_a = x[31:0];  mul_b = cst[31:0];  end
      2'd1:    begin mul_a = x[31:0];  mul_b = cst[63:32]; end
      default: begin mul_a = x[63:32]; mul_b = cst[31:0];  end
    endcase
  end

  // Pick the hash word being reduced
  always_comb begin
    case (wsel)
      2'd0:    word_sel = ha[31:0];
      2'd1:    word_sel = ha[63:32];
      2'd2:    word_sel = hb[31:0];
      default: word_sel = hb[63:32];
    endcase
  end

  // Remainder by reciprocal multiplication, then one conditional subtract
  assign q_est    = qprod[64:32+RW];
  assign qd       = 32'(q_est) * DIV_W;
  assign diff     = word_sel - qd;
  assign rem_fix  = (r0 >= DIVISOR) ? RW'(r0 - DIVISOR) : r0[RW-1:0];
  assign mixed    = (x ^ stbb_pkg::MM_SEED_LEN) + stbb_pkg::MM_SEED_LEN;
  assign red_last = busy && !start && (op == stbb_pkg::OP_DIV) &&
                    (dcnt == 2'd2) && (wsel == 2'd3);

  // Control of the hash program
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pc   <= '0;
      ph   <= '0;
      dcnt <= '0;
      wsel <= '0;
    end else begin
      done <= red_last;
      if (start) begin
        busy <= 1'b1;
        pc   <= '0;
        ph   <= '0;
      end else if (busy) begin
        case (op)
          stbb_pkg::OP_MUL: begin
            ph <= ph + 2'd1;
            if (ph == 2'd3) pc <= pc + 1'b1;
          end
          stbb_pkg::OP_FIN: begin
            pc   <= pc + 1'b1;
            wsel <= '0;
            dcnt <= '0;
          end
          stbb_pkg::OP_DIV: begin
            dcnt <= (dcnt == 2'd2) ? 2'd0 : dcnt + 2'd1;
            if (dcnt == 2'd2) begin
              wsel <= wsel + 2'd1;
              if (wsel == 2'd3) busy <= 1'b0;
            end
          end
          default: pc <= pc + 1'b1;
        endcase
      end
    end
  end

  // Datapath of the hash program
  always_ff @(posedge clk) begin
    if (start) begin
      x <= key;
    end else if (busy) begin
      case (op)
        stbb_pkg::OP_MUL: begin
          prod <= mul_a * mul_b;
          case (ph)
            2'd1:    acc <= prod;
            2'd2:    acc <= acc + {prod[31:0], 32'b0};
            2'd3:    x   <= acc + {prod[31:0], 32'b0};
            default: ;
          endcase
        end
        stbb_pkg::OP_ROT:  x <= {x[32:0], x[63:33]};
        stbb_pkg::OP_MIX: begin
          x  <= mixed;
          hb <= mixed + stbb_pkg::MM_SEED_LEN;
        end
        stbb_pkg::OP_XS:   x <= x ^ (x >> 33);
        stbb_pkg::OP_SWAP: begin
          ha <= x;
          x  <= hb;
        end
        stbb_pkg::OP_FIN: begin
          ha <= ha + x;
          hb <= ha + x + x;
        end
        default: begin
          // Three steps per word: estimate quotient, subtract, correct
          case (dcnt)
            2'd0:    qprod <= 65'(word_sel) * 65'(RECIP);
            2'd1:    r0    <= diff[RW:0];
            default: idx[wsel] <= rem_fix;
          endcase
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sorted_table_builder_bloom_unit.sv
// Top level: table bookkeeping, filter memory and request/result channels.
`timescale 1ns / 1ps
`default_nettype none
// Sorted table builder with a Bloom filter held in one single-port memory of
// FILTER_WORDS 64-bit words. After reset the block runs a clearing pass over
// every filter word before it takes requests; a start request reports in the
// next cycle and then runs the same pass. A read request reports from the fetch
// state, after one memory read. An add request reports in the next cycle; if
// it fits, the block then hashes the key with one shared 32x32 multiplier (six
// 64-bit products plus 10 other steps), reduces each of the four hash words
// modulo FILTER_BITS by reciprocal multiplication, and finally does four
// read-modify-write passes on the filter memory. A new request is taken once
// the previous result is delivered and the block idles.
module sorted_table_builder_bloom_unit #(
  parameter int FILTER_BITS       = 10240,
  parameter int HEADER_BYTES      = 32,
  parameter int INDEX_ENTRY_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] key,
  input  logic [20:0] value_length,
  input  logic [7:0]  word_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [20:0] data_offset,
  output logic [17:0] key_count,
  output logic [63:0] min_key,
  output logic [63:0] max_key,
  output logic [31:0] table_size,
  output logic [63:0] filter_word
);

  localparam int FILTER_WORDS = (FILTER_BITS + 63) / 64;
  localparam int AW = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
  localparam int RW = $clog2(FILTER_BITS);
  localparam logic [31:0] START_SIZE = 32'(HEADER_BYTES + FILTER_BITS);
  localparam logic [AW-1:0] LAST_WORD = AW'(FILTER_WORDS - 1);
  localparam logic [17:0] COUNT_MAX = 18'h3FFFF;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_FETCH = 3'd5;

  logic [2:0]          state;
  logic [31:0]         size_limit;
  logic [31:0]         size_bytes;
  logic [17:0]         entry_count;
  logic [21:0]         next_offset;
  logic [63:0]         first_key;
  logic [63:0]         last_key;
  logic [AW-1:0]       clr_addr;
  logic [1:0]          k;
  logic                in_range;
  logic                hash_start;
  logic                hash_done;
  logic [3:0][RW-1:0]  idx;
  logic [RW-1:0]       cur_idx;
  logic [32:0]         grown;
  logic                fits;
  logic                add_ok;
  logic                take;

  logic [63:0]         mem [FILTER_WORDS];
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic [63:0]         mem_wdata;
  logic [63:0]         mem_rdata;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == ST_IDLE) && !out_valid;
  assign take       = in_valid && in_ready;
  assign grown      = 33'(size_bytes) + 33'(INDEX_ENTRY_BYTES) + 33'(value_length);
  assign fits       = grown <= 33'(size_limit);
  assign add_ok     = (cmd == stbb_pkg::CMD_ADD) && fits;
  assign hash_start = take && add_ok;
  assign cur_idx    = idx[k];

  assign key_count  = entry_count;
  assign min_key    = first_key;
  assign max_key    = last_key;
  assign table_size = size_bytes;

  stbb_hash #(
    .FILTER_BITS (FILTER_BITS),
    .RW          (RW)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key),
    .done  (hash_done),
    .idx   (idx)
  );

  // Steer the memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = mem_rdata | (64'd1 << cur_idx[5:0]);
    unique case (state)
      ST_CLEAR: begin
        mem_addr  = clr_addr;
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_RD:   mem_addr = AW'(cur_idx >> 6);
      ST_WR: begin
        mem_addr = AW'(cur_idx >> 6);
        mem_we   = 1'b1;
      end
      default: mem_addr = AW'(word_index);
    endcase
  end

  // Filter memory, read-first
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  // Hold the size limit
  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= 32'd2097152;
    end else if (cfg_valid && cfg_ready) begin
      size_limit <= cfg_data;
    end
  end

  // Sequence requests, bookkeeping and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      size_bytes  <= START_SIZE;
      entry_count <= '0;
      next_offset <= '0;
      first_key   <= '0;
      last_key    <= '0;
      k           <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_WORD) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (take) begin
            accepted    <= add_ok;
            data_offset <= add_ok ? next_offset[20:0] : '0;
            filter_word <= '0;
            case (cmd)
              stbb_pkg::CMD_START: begin
                size_bytes  <= START_SIZE;
                entry_count <= '0;
                next_offset <= '0;
                first_key   <= '0;
                last_key    <= '0;
                clr_addr    <= '0;
                out_valid   <= 1'b1;
                state       <= ST_CLEAR;
              end
              stbb_pkg::CMD_ADD: begin
                out_valid <= 1'b1;
                if (fits) begin
                  size_bytes  <= grown[31:0];
                  next_offset <= next_offset + 22'(value_length);
                  if (entry_count == '0) first_key <= key;
                  last_key <= key;
                  if (entry_count != COUNT_MAX) entry_count <= entry_count + 18'd1;
                  state <= ST_HASH;
                end
              end
              stbb_pkg::CMD_READ: begin
                in_range <= 32'(word_index) < 32'(FILTER_WORDS);
                state    <= ST_FETCH;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        ST_HASH: begin
          k <= '0;
          if (hash_done) state <= ST_RD;
        end
        ST_RD: state <= ST_WR;
        ST_WR: begin
          k <= k + 2'd1;
          state <= (k == 2'd3) ? ST_IDLE : ST_RD;
        end
        ST_FETCH: begin
          filter_word <= in_range ? mem_rdata : '0;
          out_valid   <= 1'b1;
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_sorted_table_builder_bloom_unit.sv
// Testbench for the sorted table builder: a directed table and random requests checked by a predictor.
`timescale 1ns / 1ps
module tb_sorted_table_builder_bloom_unit;

  localparam logic [1:0] CMD_NONE = 2'd3;  // unused command code
  localparam int FBITS = 10240;
  localparam int FWORDS = FBITS / 64;
  localparam int BASE_SIZE = 32 + FBITS;
  localparam int SETTLE = 400;             // add keeps working after its result
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic        acc;
    logic [20:0] off;
    logic [17:0] cnt;
    logic [63:0] mn;
    logic [63:0] mx;
    logic [31:0] sz;
    logic [63:0] fw;
  } table_res_t;

  typedef struct {
    logic [1:0]  c;
    logic [63:0] k;
    logic [20:0] v;
    logic [7:0]  w;
    bit          typed;
    table_res_t  r;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = stbb_pkg::CMD_START;
  logic [63:0] key = '0;
  logic [20:0] value_length = '0;
  logic [7:0]  word_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic [20:0] data_offset;
  logic [17:0] key_count;
  logic [63:0] min_key;
  logic [63:0] max_key;
  logic [31:0] table_size;
  logic [63:0] filter_word;

  sorted_table_builder_bloom_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .key(key),
    .value_length(value_length), .word_index(word_index),
    .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
    .data_offset(data_offset), .key_count(key_count), .min_key(min_key),
    .max_key(max_key), .table_size(table_size), .filter_word(filter_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predicted table state
  logic [31:0] pr_limit = 32'd2097152;
  logic [31:0] pr_size = BASE_SIZE;
  logic [17:0] pr_count = '0;
  logic [21:0] pr_offset = '0;
  logic [63:0] pr_first = '0;
  logic [63:0] pr_last = '0;
  logic [63:0] pr_filter [FWORDS];

  table_res_t expected_q[$];
  request_t   table_rows[$];
  int         errors = 0;
  bit         calm = 1'b0;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] fmix(input logic [63:0] x);
    x = x ^ (x >> 33);
    x = x * 64'hff51afd7ed558ccd;
    x = x ^ (x >> 33);
    x = x * 64'hc4ceb9fe1a85ec53;
    return x ^ (x >> 33);
  endfunction

  // MurmurHash3 x64 128 of one 8-byte key, seed 1, as four 32-bit words
  function automatic logic [127:0] murmur_key(input logic [63:0] k);
    logic [63:0] h1, h2, k1;
    k1 = k * 64'h87c37b91114253d5;
    k1 = rotl(k1, 31);
    k1 = k1 * 64'h4cf5ad432745937f;
    h1 = 64'd1 ^ k1 ^ 64'd8;
    h2 = 64'd1 ^ 64'd8;
    h1 = h1 + h2;
    h2 = h2 + h1;
    h1 = fmix(h1);
    h2 = fmix(h2);
    h1 = h1 + h2;
    h2 = h2 + h1;
    return {h2, h1};
  endfunction

  function automatic void clear_table();
    pr_size = BASE_SIZE;
    pr_count = '0;
    pr_offset = '0;
    pr_first = '0;
    pr_last = '0;
    for (int i = 0; i < FWORDS; i++) pr_filter[i] = '0;
  endfunction

  // Advance the predicted state by one request and return its result
  function automatic table_res_t table_step(input request_t q);
    table_res_t r;
    logic [32:0] grown;
    logic [127:0] h;
    logic [31:0] b;
    r.acc = 1'b0;
    r.off = '0;
    r.fw = '0;
    case (q.c)
      stbb_pkg::CMD_START: clear_table();
      stbb_pkg::CMD_ADD: begin
        grown = {1'b0, pr_size} + 33'd12 + {12'd0, q.v};
        if (grown <= {1'b0, pr_limit}) begin
          r.acc = 1'b1;
          r.off = pr_offset[20:0];
          pr_size = grown[31:0];
          pr_offset = pr_offset + {1'b0, q.v};
          if (pr_count == 0) pr_first = q.k;
          pr_last = q.k;
          if (pr_count != '1) pr_count = pr_count + 1'b1;
          h = murmur_key(q.k);
          for (int i = 0; i < 4; i++) begin
            b = h[32*i +: 32] % FBITS;
            pr_filter[b / 64][b % 64] = 1'b1;
          end
        end
      end
      stbb_pkg::CMD_READ: if (q.w < FWORDS) r.fw = pr_filter[q.w];
      default: ;
    endcase
    r.cnt = pr_count;
    r.mn = pr_first;
    r.mx = pr_last;
    r.sz = pr_size;
    return r;
  endfunction

  function automatic void row(input logic [1:0] c, input logic [63:0] k, input logic [20:0] v,
                              input logic [7:0] w, input bit typed = 0,
                              input logic a = 0, input logic [20:0] o = 0,
                              input logic [17:0] n = 0, input logic [63:0] mn = 0,
                              input logic [63:0] mx = 0, input logic [31:0] s = 0);
    request_t q;
    q.c = c; q.k = k; q.v = v; q.w = w; q.typed = typed;
    q.r.acc = a; q.r.off = o; q.r.cnt = n; q.r.mn = mn; q.r.mx = mx; q.r.sz = s;
    q.r.fw = '0;
    table_rows = {table_rows, q};
  endfunction

  // Present one request, hold it until taken, then record its expected result
  task automatic send(input request_t q);
    table_res_t r;
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= q.c;
    key <= q.k;
    value_length <= q.v;
    word_index <= q.w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = table_step(q);
    if (q.typed) r = q.r;
    expected_q = {expected_q, r};
  endtask

  // Wait until the block is idle, then write the size limit
  task automatic write_limit(input logic [31:0] lim);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pr_limit = lim;
  endtask

  // One random request: mostly ascending adds and reads inside a table
  task automatic random_request(inout logic [63:0] next_key);
    request_t q;
    int pick;
    pick = $urandom_range(99);
    q.typed = 0;
    q.k = next_key;
    q.v = ($urandom_range(9) == 0) ? 21'($urandom) : 21'($urandom_range(300));
    q.w = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(FWORDS - 1));
    if (pick < 55) q.c = stbb_pkg::CMD_ADD;
    else if (pick < 85) q.c = stbb_pkg::CMD_READ;
    else if (pick < 91) q.c = stbb_pkg::CMD_START;
    else if (pick < 95) q.c = CMD_NONE;
    else begin
      q.c = stbb_pkg::CMD_ADD;
      q.k = {$urandom, $urandom};
    end
    if (q.c == stbb_pkg::CMD_START) next_key = 64'($urandom_range(1000));
    else if (q.c == stbb_pkg::CMD_ADD)
      next_key = next_key + (($urandom_range(3) == 0) ? {$urandom, $urandom} >> $urandom_range(63)
                                                      : 64'($urandom_range(1, 50)));
    send(q);
  endtask

  // Take results and compare them with the oldest expectation
  always @(posedge clk) begin
    table_res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request waiting");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (accepted !== e.acc) begin
            $error("accepted exp %0h got %0h", e.acc, accepted); errors++;
          end
          if (data_offset !== e.off) begin
            $error("data_offset exp %0h got %0h", e.off, data_offset); errors++;
          end
          if (key_count !== e.cnt) begin
            $error("key_count exp %0h got %0h", e.cnt, key_count); errors++;
          end
          if (min_key !== e.mn) begin
            $error("min_key exp %0h got %0h", e.mn, min_key); errors++;
          end
          if (max_key !== e.mx) begin
            $error("max_key exp %0h got %0h", e.mx, max_key); errors++;
          end
          if (table_size !== e.sz) begin
            $error("table_size exp %0h got %0h", e.sz, table_size); errors++;
          end
          if (filter_word !== e.fw) begin
            $error("filter_word exp %0h got %0h", e.fw, filter_word); errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // Stop a hung run: count cycles with no handshake on any channel
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (++idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] next_key;
    logic [31:0] limits [5];
    for (int i = 0; i < FWORDS; i++) pr_filter[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table: reset state, extremes, rejects, exact fit, reads
    row(stbb_pkg::CMD_READ, '0, '0, 8'd0, 1, 0, 0, 0, 0, 0, BASE_SIZE);
    row(CMD_NONE, '1, '1, 8'hff, 1, 0, 0, 0, 0, 0, BASE_SIZE);
    row(stbb_pkg::CMD_ADD, '0, '0, 8'd0, 1, 1, 0, 1, 0, 0, BASE_SIZE + 12);
    row(stbb_pkg::CMD_ADD, '1, '1, 8'hff, 1, 0, 0, 1, 0, 0, BASE_SIZE + 12);
    row(stbb_pkg::CMD_ADD, 64'd5, 21'd100, 8'd3);
    row(stbb_pkg::CMD_ADD, 64'd1, 21'd7, 8'd0);
    row(stbb_pkg::CMD_ADD, 64'h0123456789abcdef, 21'h0aaaaa, 8'd0);
    row(stbb_pkg::CMD_ADD, 64'hfedcba9876543210, 21'h155555, 8'd0);
    row(stbb_pkg::CMD_READ, '0, '0, 8'd0);
    row(stbb_pkg::CMD_READ, '0, '0, 8'd80);
    row(stbb_pkg::CMD_READ, '0, '0, 8'd159);
    row(stbb_pkg::CMD_READ, '0, '0, 8'd160);
    row(stbb_pkg::CMD_READ, '1, '1, 8'hff);
    row(CMD_NONE, '0, '0, 8'd0);
    row(stbb_pkg::CMD_START, '1, '1, 8'hff, 1, 0, 0, 0, 0, 0, BASE_SIZE);
    row(stbb_pkg::CMD_ADD, 64'h8000000000000000, 21'd2086868, 8'd0, 1, 1, 0, 1,
        64'h8000000000000000, 64'h8000000000000000, 32'd2097152);
    row(stbb_pkg::CMD_ADD, 64'h8000000000000001, 21'd0, 8'd0, 1, 0, 0, 1,
        64'h8000000000000000, 64'h8000000000000000, 32'd2097152);
    row(stbb_pkg::CMD_READ, '0, '0, 8'd1);
    row(stbb_pkg::CMD_READ, '0, '0, 8'd100);
    foreach (table_rows[i]) send(table_rows[i]);

    // Random phases, each under its own size limit
    limits[0] = 32'hffffffff;
    limits[1] = 32'd0;
    limits[2] = 32'd2097152;
    limits[3] = BASE_SIZE + $urandom_range(50000);
    limits[4] = $urandom;
    next_key = '0;
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      row(stbb_pkg::CMD_START, '0, '0, '0);
      send(table_rows[$]);
      for (int n = 0; n < 106; n++) begin
        calm = (p == 2 && n >= 30 && n < 80);
        random_request(next_key);
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
